[rtl/frm_pkg.sv]
// ----------------------------------------------------------------------------
// frm_pkg
// Shared types, codes and constant tables for the format string renderer.
// ----------------------------------------------------------------------------
package frm_pkg;

  typedef logic [3:0] frm_addr_t;

  localparam logic [1:0] OP_FMT = 2'd0;
  localparam logic [1:0] OP_INT = 2'd1;
  localparam logic [1:0] OP_STR = 2'd2;

  localparam logic [1:0] CONV_NONE = 2'd0;
  localparam logic [1:0] CONV_S    = 2'd1;
  localparam logic [1:0] CONV_D    = 2'd2;
  localparam logic [1:0] CONV_X    = 2'd3;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_S       = 8'h73;
  localparam logic [7:0] CH_D       = 8'h64;
  localparam logic [7:0] CH_X       = 8'h78;
  localparam logic [7:0] CH_MINUS   = 8'h2d;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_A_LESS10 = 8'h57;

  localparam logic [3:0] POS_DEC_TOP  = 4'd9;
  localparam logic [3:0] POS_HEX_TOP  = 4'd7;
  localparam logic [3:0] POS_NULL_TOP = 4'd5;

  // microcode addresses
  localparam frm_addr_t A_IDLE  = 4'd0;
  localparam frm_addr_t A_ECHO  = 4'd1;
  localparam frm_addr_t A_COUNT = 4'd2;
  localparam frm_addr_t A_NEG   = 4'd3;
  localparam frm_addr_t A_DSKIP = 4'd4;
  localparam frm_addr_t A_DEMIT = 4'd5;
  localparam frm_addr_t A_HSKIP = 4'd6;
  localparam frm_addr_t A_HEMIT = 4'd7;
  localparam frm_addr_t A_NULL  = 4'd8;

  // emit source
  localparam logic [2:0] E_NONE  = 3'd0;
  localparam logic [2:0] E_CHAR  = 3'd1;
  localparam logic [2:0] E_MINUS = 3'd2;
  localparam logic [2:0] E_DIGIT = 3'd3;
  localparam logic [2:0] E_NULL  = 3'd4;
  localparam logic [2:0] E_COUNT = 3'd5;

  // jump condition
  localparam logic [1:0] C_INPUT  = 2'd0;
  localparam logic [1:0] C_ALWAYS = 2'd1;
  localparam logic [1:0] C_POS0   = 2'd2;
  localparam logic [1:0] C_LEAD   = 2'd3;

  // last flag
  localparam logic [1:0] L_NONE   = 2'd0;
  localparam logic [1:0] L_ALWAYS = 2'd1;
  localparam logic [1:0] L_POS0   = 2'd2;

  typedef struct packed {
    logic [2:0] emit;
    logic [1:0] cond;
    frm_addr_t  target;
    logic       pos_dec;
    logic [1:0] last_mode;
    logic       hex;
  } frm_uword_t;

  typedef struct packed {
    logic [7:0]  ch;
    logic        is_count;
    logic [31:0] count;
    logic        last;
  } frm_result_t;

  // k * 10^pos, wide enough for nine thousand million
  function automatic logic [35:0] frm_dec_step(input logic [3:0] pos, input logic [3:0] k);
    logic [35:0] p;
    case (pos)
      4'd0:    p = 36'd1;
      4'd1:    p = 36'd10;
      4'd2:    p = 36'd100;
      4'd3:    p = 36'd1000;
      4'd4:    p = 36'd10000;
      4'd5:    p = 36'd100000;
      4'd6:    p = 36'd1000000;
      4'd7:    p = 36'd10000000;
      4'd8:    p = 36'd100000000;
      4'd9:    p = 36'd1000000000;
      default: p = 36'd0;
    endcase
    return p * {32'd0, k};
  endfunction

  function automatic logic [7:0] frm_digit_char(input logic [3:0] d);
    if (d < 4'd10) begin
      return CH_ZERO + {4'd0, d};
    end
    return CH_A_LESS10 + {4'd0, d};
  endfunction

  function automatic logic [7:0] frm_null_char(input logic [3:0] pos);
    logic [7:0] c;
    case (pos)
      4'd5:    c = 8'h28;
      4'd4:    c = 8'h6e;
      4'd3:    c = 8'h75;
      4'd2:    c = 8'h6c;
      4'd1:    c = 8'h6c;
      default: c = 8'h29;
    endcase
    return c;
  endfunction

endpackage

[rtl/format_string_renderer_top.sv]
// ----------------------------------------------------------------------------
// format_string_renderer_top
// Renders a printf-style stream with s, d and x conversions.
// ----------------------------------------------------------------------------
// A transaction is taken whenever the sequencer is at its idle step, even
// while a result still sits in the output register. Items that only change
// conversion state leave the sequencer at that step. An echoed character,
// the final count, a null string, a hex argument and a decimal argument each
// run a sequence of steps; for numbers the sequencer walks all digit
// positions from the top, one per cycle, skipping leading zeros before it
// emits one character per cycle. Each result step waits while the output
// register is full and not being taken.
module format_string_renderer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [7:0]  in_format_char,
  input  logic signed [31:0] in_int_value,
  input  logic [7:0]  in_str_char,
  input  logic        in_str_is_null,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_char,
  output logic        out_is_count,
  output logic [31:0] out_char_count,
  output logic        out_last
);
  import frm_pkg::*;

  frm_addr_t   upc_r, upc_nxt;
  logic [3:0]  pos_r, pos_nxt;
  logic [31:0] mag_r, mag_nxt;
  logic [7:0]  char_r, char_nxt;
  logic        after_r, after_nxt;
  logic [1:0]  pend_r, pend_nxt;
  logic [31:0] total_r, total_nxt;

  frm_uword_t  uw;
  frm_result_t res;
  frm_result_t out_data;
  logic        space;
  logic        emits;
  logic        fire;
  logic        cond_true;
  logic        load;
  logic [3:0]  digit;
  logic [31:0] sub_val;
  logic [31:0] total_inc;
  logic [31:0] iv;

  frm_ucode_rom u_rom (
    .addr  (upc_r),
    .uword (uw)
  );

  frm_digit_unit u_digit (
    .mag     (mag_r),
    .pos     (pos_r),
    .hex     (uw.hex),
    .digit   (digit),
    .sub_val (sub_val)
  );

  frm_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .load_data (res),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign in_ready  = (uw.cond == C_INPUT);
  assign emits     = (uw.emit != E_NONE);
  assign fire      = !emits || space;
  assign total_inc = (total_r == 32'hFFFF_FFFF) ? total_r : total_r + 32'd1;
  assign iv        = in_int_value;

  always_comb begin
    case (uw.cond)
      C_ALWAYS: cond_true = 1'b1;
      C_POS0:   cond_true = (pos_r == 4'd0);
      C_LEAD:   cond_true = (digit != 4'd0) || (pos_r == 4'd0);
      default:  cond_true = 1'b0;
    endcase
  end

  always_comb begin
    res.ch       = CH_NUL;
    res.is_count = 1'b0;
    res.count    = total_inc;
    case (uw.emit)
      E_CHAR:  res.ch = char_r;
      E_MINUS: res.ch = CH_MINUS;
      E_DIGIT: res.ch = frm_digit_char(digit);
      E_NULL:  res.ch = frm_null_char(pos_r);
      E_COUNT: begin
        res.is_count = 1'b1;
        res.count    = total_r;
      end
      default: res.ch = CH_NUL;
    endcase
    case (uw.last_mode)
      L_ALWAYS: res.last = 1'b1;
      L_POS0:   res.last = (pos_r == 4'd0);
      default:  res.last = 1'b0;
    endcase
  end

  always_comb begin
    upc_nxt   = upc_r;
    pos_nxt   = pos_r;
    mag_nxt   = mag_r;
    char_nxt  = char_r;
    after_nxt = after_r;
    pend_nxt  = pend_r;
    total_nxt = total_r;
    load      = 1'b0;
    if (uw.cond == C_INPUT) begin
      if (in_valid) begin
        unique case (in_operation)
          OP_FMT: begin
            if (in_format_char == CH_NUL) begin
              after_nxt = 1'b0;
              pend_nxt  = CONV_NONE;
              upc_nxt   = A_COUNT;
            end else if (after_r) begin
              after_nxt = 1'b0;
              if (in_format_char == CH_S) begin
                pend_nxt = CONV_S;
              end else if (in_format_char == CH_D) begin
                pend_nxt = CONV_D;
              end else if (in_format_char == CH_X) begin
                pend_nxt = CONV_X;
              end
            end else if (in_format_char == CH_PERCENT) begin
              after_nxt = 1'b1;
            end else begin
              char_nxt = in_format_char;
              upc_nxt  = A_ECHO;
            end
          end
          OP_INT: begin
            if (pend_r == CONV_D) begin
              pend_nxt = CONV_NONE;
              pos_nxt  = POS_DEC_TOP;
              if (iv[31]) begin
                mag_nxt = ~iv + 32'd1;
                upc_nxt = A_NEG;
              end else begin
                mag_nxt = iv;
                upc_nxt = A_DSKIP;
              end
            end else if (pend_r == CONV_X) begin
              pend_nxt = CONV_NONE;
              pos_nxt  = POS_HEX_TOP;
              mag_nxt  = iv;
              upc_nxt  = A_HSKIP;
            end
          end
          OP_STR: begin
            if (pend_r == CONV_S) begin
              if (in_str_is_null) begin
                pend_nxt = CONV_NONE;
                pos_nxt  = POS_NULL_TOP;
                upc_nxt  = A_NULL;
              end else if (in_str_char == CH_NUL) begin
                pend_nxt = CONV_NONE;
              end else begin
                char_nxt = in_str_char;
                upc_nxt  = A_ECHO;
              end
            end
          end
          default: begin
            upc_nxt = A_IDLE;
          end
        endcase
      end
    end else if (fire) begin
      if (cond_true) begin
        upc_nxt = uw.target;
      end else if (uw.pos_dec) begin
        pos_nxt = pos_r - 4'd1;
      end
      if (emits) begin
        load      = 1'b1;
        total_nxt = (uw.emit == E_COUNT) ? 32'd0 : total_inc;
      end
      if (uw.emit == E_DIGIT && !uw.hex) begin
        mag_nxt = mag_r - sub_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r   <= A_IDLE;
      pos_r   <= 4'd0;
      after_r <= 1'b0;
      pend_r  <= CONV_NONE;
      total_r <= 32'd0;
    end else begin
      upc_r   <= upc_nxt;
      pos_r   <= pos_nxt;
      after_r <= after_nxt;
      pend_r  <= pend_nxt;
      total_r <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r  <= mag_nxt;
    char_r <= char_nxt;
  end

  assign out_char       = out_data.ch;
  assign out_is_count   = out_data.is_count;
  assign out_char_count = out_data.count;
  assign out_last       = out_data.last;

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_DEC_TOP)
    else $error("digit position out of range");

  a_count_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (load && res.is_count) |=> (total_r == 32'd0))
    else $error("character total not cleared after count");

  a_dec_sub: assert property (@(posedge clk) disable iff (!rst_n)
    (upc_r == A_DEMIT) |-> (sub_val <= mag_r))
    else $error("decimal step exceeds remaining magnitude");

  a_count_last: assert property (@(posedge clk) disable iff (!rst_n)
    (load && res.is_count) |-> res.last)
    else $error("count transaction not marked last");

endmodule

[rtl/frm_ucode_rom.sv]
// ----------------------------------------------------------------------------
// frm_ucode_rom
// Control store: one control word per sequencer step.
// ----------------------------------------------------------------------------
module frm_ucode_rom (
  input  frm_pkg::frm_addr_t  addr,
  output frm_pkg::frm_uword_t uword
);
  import frm_pkg::*;

  always_comb begin
    unique case (addr)
      A_ECHO:  uword = '{emit: E_CHAR,  cond: C_ALWAYS, target: A_IDLE,
                         pos_dec: 1'b0, last_mode: L_ALWAYS, hex: 1'b0};
      A_COUNT: uword = '{emit: E_COUNT, cond: C_ALWAYS, target: A_IDLE,
                         pos_dec: 1'b0, last_mode: L_ALWAYS, hex: 1'b0};
      A_NEG:   uword = '{emit: E_MINUS, cond: C_ALWAYS, target: A_DSKIP,
                         pos_dec: 1'b0, last_mode: L_NONE, hex: 1'b0};
      A_DSKIP: uword = '{emit: E_NONE,  cond: C_LEAD,   target: A_DEMIT,
                         pos_dec: 1'b1, last_mode: L_NONE, hex: 1'b0};
      A_DEMIT: uword = '{emit: E_DIGIT, cond: C_POS0,   target: A_IDLE,
                         pos_dec: 1'b1, last_mode: L_POS0, hex: 1'b0};
      A_HSKIP: uword = '{emit: E_NONE,  cond: C_LEAD,   target: A_HEMIT,
                         pos_dec: 1'b1, last_mode: L_NONE, hex: 1'b1};
      A_HEMIT: uword = '{emit: E_DIGIT, cond: C_POS0,   target: A_IDLE,
                         pos_dec: 1'b1, last_mode: L_POS0, hex: 1'b1};
      A_NULL:  uword = '{emit: E_NULL,  cond: C_POS0,   target: A_IDLE,
                         pos_dec: 1'b1, last_mode: L_POS0, hex: 1'b0};
      default: uword = '{emit: E_NONE,  cond: C_INPUT,  target: A_IDLE,
                         pos_dec: 1'b0, last_mode: L_NONE, hex: 1'b0};
    endcase
  end

endmodule

[rtl/frm_digit_unit.sv]
// ----------------------------------------------------------------------------
// frm_digit_unit
// Digit extraction: decimal digit by compare bank, hex nibble by select.
// ----------------------------------------------------------------------------
module frm_digit_unit (
  input  logic [31:0] mag,
  input  logic [3:0]  pos,
  input  logic        hex,
  output logic [3:0]  digit,
  output logic [31:0] sub_val
);
  import frm_pkg::*;

  logic [3:0]  dec_digit;
  logic [3:0]  hex_digit;
  logic [35:0] step_val;

  always_comb begin
    dec_digit = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if ({4'd0, mag} >= frm_dec_step(pos, 4'(k))) begin
        dec_digit = 4'(k);
      end
    end
  end

  assign hex_digit = mag[{pos[2:0], 2'b00} +: 4];
  assign step_val  = frm_dec_step(pos, dec_digit);
  assign sub_val   = step_val[31:0];
  assign digit     = hex ? hex_digit : dec_digit;

endmodule

[rtl/frm_out_reg.sv]
// ----------------------------------------------------------------------------
// frm_out_reg
// Output register for the result channel.
// ----------------------------------------------------------------------------
module frm_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  frm_pkg::frm_result_t load_data,
  output logic                space,
  output logic                out_valid,
  input  logic                out_ready,
  output frm_pkg::frm_result_t out_data
);
  import frm_pkg::*;

  logic        valid_r;
  logic        valid_nxt;
  frm_result_t data_r;

  assign space     = !valid_r || out_ready;
  assign valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule
